>>> hw/rtl/bloom_bright_pass_soft_knee_defines.svh
// Assertion helpers for the bright-pass block.
`ifndef BLOOM_BRIGHT_PASS_SOFT_KNEE_DEFINES_SVH
`define BLOOM_BRIGHT_PASS_SOFT_KNEE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BBPSK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BBPSK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define BBPSK_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define BBPSK_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> hw/rtl/bbpsk_pkg.sv
package bbpsk_pkg;

    localparam int CHANNEL_BITS_DEF  = 24;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr[2]
    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_KNEE      = 1'b1;

endpackage

>>> hw/rtl/bbpsk_pix_if.sv
interface bbpsk_pix_in_if #(
    parameter int CHANNEL_BITS = bbpsk_pkg::CHANNEL_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_in;
    logic [CHANNEL_BITS-1:0] green_in;
    logic [CHANNEL_BITS-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

interface bbpsk_pix_out_if #(
    parameter int CHANNEL_BITS = bbpsk_pkg::CHANNEL_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red_out;
    logic [CHANNEL_BITS-1:0] green_out;
    logic [CHANNEL_BITS-1:0] blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

>>> hw/rtl/bbpsk_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, LANES dividends
// sharing one divisor. The caller guarantees num >> QW < den, so the
// quotient fits in QW bits.
module bbpsk_div_pipe #(
    parameter int RW    = bbpsk_pkg::CHANNEL_BITS_DEF + 2,
    parameter int QW    = bbpsk_pkg::CHANNEL_BITS_DEF,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           in_valid,
    input  logic [LANES-1:0][RW+QW-1:0]    num,
    input  logic [RW-1:0]                  den,
    input  logic [SW-1:0]                  side,
    output logic                           out_valid,
    output logic [LANES-1:0][QW-1:0]       quo,
    output logic [SW-1:0]                  side_out
);

    logic [QW-1:0] valid_reg;
    logic [RW-1:0] den_reg  [QW];
    logic [SW-1:0] side_reg [QW];
    logic [RW-1:0] rem_reg  [QW][LANES];
    logic [QW-1:0] lq_reg   [QW][LANES];
    logic [RW-1:0] rem_next [QW][LANES];
    logic [QW-1:0] lq_next  [QW][LANES];

    // Shift the next dividend bit into the remainder, subtract if it fits;
    // the quotient bit enters where the dividend bit left.
    function automatic logic [RW+QW-1:0] div_step(
        input logic [RW-1:0] rem,
        input logic [QW-1:0] lq,
        input logic [RW-1:0] dv
    );
        logic [RW:0] t;
        logic [RW:0] diff;
        logic        ge;
        t    = {rem, lq[QW-1]};
        ge   = (t >= {1'b0, dv});
        diff = t - {1'b0, dv};
        if (ge)
        begin
            return {diff[RW-1:0], lq[QW-2:0], 1'b1};
        end
        return {t[RW-1:0], lq[QW-2:0], 1'b0};
    endfunction

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            {rem_next[0][l], lq_next[0][l]} =
                div_step(num[l][RW+QW-1:QW], num[l][QW-1:0], den);
        end
        for (int s = 1; s < QW; s++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                {rem_next[s][l], lq_next[s][l]} =
                    div_step(rem_reg[s-1][l], lq_reg[s-1][l], den_reg[s-1]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QW-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0]  <= den;
            side_reg[0] <= side;
            for (int s = 1; s < QW; s++)
            begin
                den_reg[s]  <= den_reg[s-1];
                side_reg[s] <= side_reg[s-1];
            end
            rem_reg <= rem_next;
            lq_reg  <= lq_next;
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign side_out  = side_reg[QW-1];

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            quo[l] = lq_reg[QW-1][l];
        end
    end

endmodule

>>> hw/rtl/bloom_bright_pass_soft_knee.sv
// Bloom bright-pass prefilter with a soft knee. Takes one RGB pixel per clock
// (unsigned fixed point, FRACTION_BITS fraction bits) and returns one scaled
// pixel per clock while the skid register is empty, using two restoring
// dividers, soft = s*s / (4*knee) and channel * contribution / brightness, each
// of which resolves one quotient bit per pipeline stage. A one-beat skid register
// behind the output holds a result that meets a stalled output and, while full,
// freezes the pipeline. threshold (byte address 0) and knee (byte address 4) are
// written through the APB port by the user only while the block is idle; the
// block does not enforce this. A knee of zero gives a hard cutoff.
`include "bloom_bright_pass_soft_knee_defines.svh"

module bloom_bright_pass_soft_knee #(
    parameter int CHANNEL_BITS  = bbpsk_pkg::CHANNEL_BITS_DEF,
    parameter int FRACTION_BITS = bbpsk_pkg::FRACTION_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bbpsk_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [bbpsk_pkg::APB_DATA_W-1:0] pwdata,
    output logic [bbpsk_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready,
    bbpsk_pix_in_if.sink                    pix_in,
    bbpsk_pix_out_if.source                 pix_out
);

    import bbpsk_pkg::*;

    localparam int CB = CHANNEL_BITS;
    localparam logic [CB-1:0] THR_RESET  = CB'(64'd1 << FRACTION_BITS);
    localparam logic [CB-1:0] KNEE_RESET = CB'(64'd1 << (FRACTION_BITS - 1));

    typedef struct packed {
        logic [2:0][CB-1:0] ch;
        logic [CB-1:0]      bright;
        logic signed [CB:0] contrib;
    } soft_side_t;

    // ---------------------------------------------------------------- config
    logic [CB-1:0] thr_reg;
    logic [CB-1:0] knee_reg;
    logic          cfg_wr;
    logic [0:0]    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            knee_reg <= KNEE_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_THRESHOLD: thr_reg  <= pwdata[CB-1:0];
                REG_KNEE:      knee_reg <= pwdata[CB-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_THRESHOLD: prdata = APB_DATA_W'(thr_reg);
            REG_KNEE:      prdata = APB_DATA_W'(knee_reg);
            default:       prdata = '0;
        endcase
    end

    // -------------------------------------------------------------- pipeline
    logic adv;
    logic out_take;
    logic h_push;

    logic               out_valid_reg;
    logic               skid_valid_reg;
    logic [2:0][CB-1:0] out_rgb_reg;
    logic [2:0][CB-1:0] skid_rgb_reg;

    logic               a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg, e_valid_reg;
    logic               f_valid_reg, g_valid_reg, h_valid_reg;
    logic [2:0][CB-1:0] a_ch_reg, b_ch_reg, c_ch_reg, d_ch_reg, e_ch_reg, f_ch_reg;
    logic [CB-1:0]      b_bright_reg, c_bright_reg, d_bright_reg, e_bright_reg;
    logic [CB-1:0]      f_bright_reg, g_bright_reg;
    logic signed [CB:0] c_contrib_reg, d_contrib_reg, e_contrib_reg;
    logic signed [CB+1:0] c_sk_reg;
    logic [CB:0]        d_s_reg;
    logic [2*CB+1:0]    e_sq_reg;
    logic [CB-1:0]      f_c_reg;
    logic               f_pass_reg, g_pass_reg;
    logic [2:0][2*CB-1:0] g_prod_reg;
    logic [2:0][CB-1:0] h_rgb_reg;

    logic [CB-1:0]      b_bright_next;
    logic [CB:0]        two_knee;
    logic [CB:0]        d_s_next;

    logic               sd_valid;
    logic [0:0][CB-1:0] sd_quo;
    soft_side_t         sd_side_in, sd_side_out;
    logic signed [CB:0] soft_s;
    logic signed [CB:0] f_eff;
    logic               f_pass_next;

    logic               cd_valid;
    logic [2:0][CB-1:0] cd_quo;
    logic               cd_pass;

    assign adv          = !skid_valid_reg;
    assign pix_in.ready = adv;

    always_comb
    begin
        b_bright_next = a_ch_reg[0];
        if (a_ch_reg[1] > b_bright_next)
        begin
            b_bright_next = a_ch_reg[1];
        end
        if (a_ch_reg[2] > b_bright_next)
        begin
            b_bright_next = a_ch_reg[2];
        end
    end

    // Clamp contribution + knee to 0..2*knee
    assign two_knee = {knee_reg, 1'b0};
    always_comb
    begin
        if (c_sk_reg[CB+1])
        begin
            d_s_next = '0;
        end
        else if (c_sk_reg[CB:0] > two_knee)
        begin
            d_s_next = two_knee;
        end
        else
        begin
            d_s_next = c_sk_reg[CB:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= pix_in.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= sd_valid;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= cd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_ch_reg      <= {pix_in.blue_in, pix_in.green_in, pix_in.red_in};
            b_ch_reg      <= a_ch_reg;
            b_bright_reg  <= b_bright_next;
            c_ch_reg      <= b_ch_reg;
            c_bright_reg  <= b_bright_reg;
            c_contrib_reg <= $signed({1'b0, b_bright_reg}) - $signed({1'b0, thr_reg});
            c_sk_reg      <= $signed({2'b00, b_bright_reg}) + $signed({2'b00, knee_reg})
                             - $signed({2'b00, thr_reg});
            d_ch_reg      <= c_ch_reg;
            d_bright_reg  <= c_bright_reg;
            d_contrib_reg <= c_contrib_reg;
            d_s_reg       <= d_s_next;
            e_ch_reg      <= d_ch_reg;
            e_bright_reg  <= d_bright_reg;
            e_contrib_reg <= d_contrib_reg;
            e_sq_reg      <= (2*CB+2)'(d_s_reg) * (2*CB+2)'(d_s_reg);
            f_ch_reg      <= sd_side_out.ch;
            f_bright_reg  <= sd_side_out.bright;
            f_c_reg       <= f_eff[CB-1:0];
            f_pass_reg    <= f_pass_next;
            g_bright_reg  <= f_bright_reg;
            g_pass_reg    <= f_pass_reg;
            for (int k = 0; k < 3; k++)
            begin
                g_prod_reg[k] <= (2*CB)'(f_ch_reg[k]) * (2*CB)'(f_c_reg);
                h_rgb_reg[k]  <= cd_pass ? cd_quo[k] : '0;
            end
        end
    end

    // soft = s*s / (4*knee); s <= 2*knee keeps the quotient at or below knee
    assign sd_side_in = '{ch: e_ch_reg, bright: e_bright_reg, contrib: e_contrib_reg};

    bbpsk_div_pipe #(
        .RW    (CB + 2),
        .QW    (CB),
        .LANES (1),
        .SW    ($bits(soft_side_t))
    ) u_soft_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (e_valid_reg),
        .num       (e_sq_reg),
        .den       ({knee_reg, 2'b00}),
        .side      (sd_side_in),
        .out_valid (sd_valid),
        .quo       (sd_quo),
        .side_out  (sd_side_out)
    );

    // Keep the larger of soft and contribution (contribution alone when knee is zero); drop dark or black pixels
    assign soft_s = $signed({1'b0, sd_quo[0]});
    always_comb
    begin
        f_eff = sd_side_out.contrib;
        if ((knee_reg != '0) && (soft_s > sd_side_out.contrib))
        begin
            f_eff = soft_s;
        end
        f_pass_next = !f_eff[CB] && (f_eff != '0) && (sd_side_out.bright != '0);
    end

    // channel * contribution / brightness; channel <= brightness keeps the
    // quotient at or below the contribution, so it never saturates
    bbpsk_div_pipe #(
        .RW    (CB),
        .QW    (CB),
        .LANES (3),
        .SW    (1)
    ) u_chan_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (g_valid_reg),
        .num       (g_prod_reg),
        .den       (g_bright_reg),
        .side      (g_pass_reg),
        .out_valid (cd_valid),
        .quo       (cd_quo),
        .side_out  (cd_pass)
    );

    // ----------------------------------------------------- output and skid
    assign out_take = out_valid_reg && pix_out.ready;
    assign h_push   = adv && h_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (h_push)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_rgb_reg <= skid_rgb_reg;
            end
        end
        else if (h_push)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_rgb_reg <= h_rgb_reg;
            end
            else
            begin
                out_rgb_reg <= h_rgb_reg;
            end
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.red_out   = out_rgb_reg[0];
    assign pix_out.green_out = out_rgb_reg[1];
    assign pix_out.blue_out  = out_rgb_reg[2];

    // ------------------------------------------------------------ assertions
    `BBPSK_ASSERT_SAME(a_skid_needs_out, clk, rst_n, skid_valid_reg, out_valid_reg, "skid beat held with empty output register")
    `BBPSK_ASSERT_SAME(a_skid_fill, clk, rst_n, $rose(skid_valid_reg), $past(out_valid_reg && !pix_out.ready && h_valid_reg), "skid filled without a blocked beat")
    `BBPSK_ASSERT_SAME(a_skid_drain, clk, rst_n, $fell(skid_valid_reg), $past(pix_out.ready), "skid drained while output stalled")
    `BBPSK_ASSERT_NEXT(a_freeze_holds, clk, rst_n, skid_valid_reg, $stable(h_valid_reg), "pipeline moved while skid was full")

endmodule
